// ===== design/srp_pkg.sv =====
// Shared types and constants for the staircase ramp profile generator.
// Used by the top level and the multiply-divide unit; depends on nothing.
`default_nettype none

package srp_pkg;

	localparam int MAX_W      = 15;  // max_reference
	localparam int STEP_W     = 8;   // step_count, step index
	localparam int TICK_W     = 16;  // ramp, hold and down tick counts
	localparam int CNT_W      = 17;  // tick counter
	localparam int REF_W      = 16;  // signed reference field
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int PROD_W     = 32;  // product register of the divider
	localparam int DIV_RADIX_BITS = 2;
	localparam int REF_BITS_DEF   = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_REFERENCE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_TICKS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DOWN_TICKS    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_ENABLE = 3'd5;

	localparam logic [MAX_W-1:0]  RST_MAX_REFERENCE = 15'd16384;
	localparam logic [STEP_W-1:0] RST_STEP_COUNT    = 8'd4;
	localparam logic [TICK_W-1:0] RST_RAMP_TICKS    = 16'd100;
	localparam logic [TICK_W-1:0] RST_HOLD_TICKS    = 16'd100;
	localparam logic [TICK_W-1:0] RST_DOWN_TICKS    = 16'd400;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LO,
		ST_HI,
		ST_FRAC,
		ST_DOWN,
		ST_EMIT
	} srp_state_t;

	// One request to the shared unit: q = floor(a * b / d)
	typedef struct packed {
		logic              start;
		logic [MAX_W-1:0]  a;
		logic [TICK_W-1:0] b;
		logic [TICK_W-1:0] d;
	} srp_div_req_t;

endpackage

`default_nettype wire

// ===== design/srp_muldiv.sv =====
// Shared multiply-divide unit: registered a*b, then restoring division,
// two quotient bits per cycle. Depends on srp_pkg.
`default_nettype none

module srp_muldiv
	import srp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire srp_div_req_t       req,
	output logic                    done,
	output logic [MAX_W-1:0]        q
);

	localparam int STEPS = PROD_W / DIV_RADIX_BITS;
	localparam int SC_W  = $clog2(STEPS);

	logic              busy_q;
	logic              done_q;
	logic [SC_W-1:0]   step_q;
	logic [PROD_W-1:0] num_q;
	logic [TICK_W-1:0] rem_q;
	logic [TICK_W-1:0] den_q;

	logic [PROD_W-2:0] prod;
	logic [TICK_W:0]   r1, t1, r2, t2;
	logic              ge1, ge2;

	assign prod = (PROD_W-1)'(req.a) * (PROD_W-1)'(req.b);

	always_comb begin
		r1  = {rem_q, num_q[PROD_W-1]};
		ge1 = r1 >= {1'b0, den_q};
		t1  = ge1 ? r1 - {1'b0, den_q} : r1;
		r2  = {t1[TICK_W-1:0], num_q[PROD_W-2]};
		ge2 = r2 >= {1'b0, den_q};
		t2  = ge2 ? r2 - {1'b0, den_q} : r2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + SC_W'(1);
				if (step_q == SC_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= {1'b0, prod};
			rem_q <= '0;
			den_q <= req.d;
		end else if (busy_q) begin
			num_q <= {num_q[PROD_W-3:0], ge1, ge2};
			rem_q <= t2[TICK_W-1:0];
		end
	end

	assign done = done_q;
	// b never exceeds d in any use, so the quotient stays within a
	assign q = num_q[MAX_W-1:0];

endmodule

`default_nettype wire

// ===== design/staircase_ramp_profile.sv =====
// Channel | dir | signals                                  | transfer when
// in      | in  | in_valid, in_stall, restart              | in_valid & !in_stall
// out     | out | out_valid, out_stall, reference,         | out_valid & !out_stall
//         |     | cycle_complete, finished                 |
// cfg     | in  | cfg_we, cfg_index, cfg_data              | cfg_we
//
// A ramp tick of a step runs three multiply-divides (step start level, step end
// level, ramp fraction) on the shared unit, one after another. A hold tick runs
// two of them, a ramp-down tick one; restart and stopped ticks run none, nor
// does the end of a ramp-down. in_stall is high while an item is worked on and
// while a finished result waits for a full output register.
// Reset is asynchronous and leaves the generator stopped until a restart.
// Top level; depends on srp_pkg and srp_muldiv.
`default_nettype none

module staircase_ramp_profile
	import srp_pkg::*;
#(
	parameter int REF_BITS = REF_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic                   restart,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic signed [REF_W-1:0]     reference,
	output logic                        cycle_complete,
	output logic                        finished,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam logic [31:0] REF_LIM = 32'((64'(1) << (REF_BITS - 1)) - 64'(1));

	// configuration
	logic [MAX_W-1:0]  max_q;
	logic [STEP_W-1:0] steps_q;
	logic [TICK_W-1:0] ramp_q;
	logic [TICK_W-1:0] hold_q;
	logic [TICK_W-1:0] down_q;
	logic              rep_q;

	// sequence state
	srp_state_t        state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [STEP_W-1:0] sidx_q;
	logic              down_phase_q;
	logic              rev_q;
	logic              stopped_q;

	// per-item work registers
	logic [STEP_W-1:0] k_q;
	logic [TICK_W-1:0] c_q;
	logic              inramp_q;
	logic [MAX_W-1:0]  lo_q;
	logic [MAX_W-1:0]  mag_q;
	logic              cyc_q;
	logic              fin_q;

	// output register
	logic              out_valid_q;
	logic [REF_W-1:0]  ref_q;
	logic              cyc_out_q;
	logic              fin_out_q;

	srp_div_req_t      div_req;
	logic              div_done;
	logic [MAX_W-1:0]  div_q;

	logic              accept, go_tick, out_free;
	logic [STEP_W-1:0] divv, k_src, klo;
	logic [STEP_W:0]   k_next, khi;
	logic              down_end, step_end;
	logic [CNT_W-1:0]  cnt_inc;
	logic [STEP_W-1:0] sidx_inc;
	logic [MAX_W-1:0]  sat;

	srp_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.q      (div_q)
	);

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign go_tick  = accept && !restart && !stopped_q;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		divv     = (steps_q == '0) ? STEP_W'(1) : steps_q;
		k_src    = (state_q == ST_IDLE) ? sidx_q : k_q;
		klo      = (k_src > divv) ? divv : k_src;
		k_next   = {1'b0, k_src} + (STEP_W+1)'(1);
		khi      = (k_next > {1'b0, divv}) ? {1'b0, divv} : k_next;
		down_end = cnt_q >= {1'b0, down_q};
		cnt_inc  = cnt_q + CNT_W'(1);
		step_end = cnt_inc >= ({1'b0, ramp_q} + {1'b0, hold_q});
		sidx_inc = sidx_q + STEP_W'(1);
		sat      = ({17'b0, mag_q} > REF_LIM) ? REF_LIM[MAX_W-1:0] : mag_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (go_tick) begin
					if (!down_phase_q)
						state_d = ST_LO;
					else if (down_end)
						state_d = ST_EMIT;
					else
						state_d = ST_DOWN;
				end
			end
			ST_LO:   if (div_done) state_d = ST_HI;
			ST_HI:   if (div_done) state_d = inramp_q ? ST_FRAC : ST_EMIT;
			ST_FRAC: if (div_done) state_d = ST_EMIT;
			ST_DOWN: if (div_done) state_d = ST_EMIT;
			ST_EMIT: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// unit requests and handshake
	always_comb begin
		div_req  = '0;
		in_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (go_tick && down_phase_q && !down_end) begin
					div_req.start = 1'b1;
					div_req.a     = max_q;
					div_req.b     = down_q - cnt_q[TICK_W-1:0];
					div_req.d     = down_q;
				end else if (go_tick && !down_phase_q) begin
					div_req.start = 1'b1;
					div_req.a     = max_q;
					div_req.b     = TICK_W'(klo);
					div_req.d     = TICK_W'(divv);
				end
			end
			ST_LO: begin
				if (div_done) begin
					div_req.start = 1'b1;
					div_req.a     = max_q;
					div_req.b     = TICK_W'(khi);
					div_req.d     = TICK_W'(divv);
				end
			end
			ST_HI: begin
				if (div_done && inramp_q) begin
					div_req.start = 1'b1;
					div_req.a     = div_q - lo_q;
					div_req.b     = c_q;
					div_req.d     = ramp_q;
				end
			end
			ST_FRAC, ST_DOWN, ST_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q        <= RST_MAX_REFERENCE;
			steps_q      <= RST_STEP_COUNT;
			ramp_q       <= RST_RAMP_TICKS;
			hold_q       <= RST_HOLD_TICKS;
			down_q       <= RST_DOWN_TICKS;
			rep_q        <= 1'b0;
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			sidx_q       <= '0;
			down_phase_q <= 1'b0;
			rev_q        <= 1'b0;
			stopped_q    <= 1'b1;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_MAX_REFERENCE: max_q   <= cfg_data[MAX_W-1:0];
					CFG_STEP_COUNT:    steps_q <= cfg_data[STEP_W-1:0];
					CFG_RAMP_TICKS:    ramp_q  <= cfg_data;
					CFG_HOLD_TICKS:    hold_q  <= cfg_data;
					CFG_DOWN_TICKS:    down_q  <= cfg_data;
					CFG_REPEAT_ENABLE: rep_q   <= cfg_data[0];
					default: begin
					end
				endcase
			end

			if (accept && restart) begin
				cnt_q        <= '0;
				sidx_q       <= '0;
				down_phase_q <= 1'b0;
				rev_q        <= 1'b0;
				stopped_q    <= 1'b0;
			end else if (go_tick) begin
				if (down_phase_q) begin
					if (down_end) begin
						// end of ramp-down: next staircase starts at counter 1
						down_phase_q <= 1'b0;
						sidx_q       <= '0;
						cnt_q        <= CNT_W'(1);
						rev_q        <= !rev_q;
						if (rev_q && !rep_q)
							stopped_q <= 1'b1;
					end else begin
						cnt_q <= cnt_inc;
					end
				end else if (step_end) begin
					cnt_q  <= '0;
					sidx_q <= sidx_inc;
					if (sidx_inc >= divv)
						down_phase_q <= 1'b1;
				end else begin
					cnt_q <= cnt_inc;
				end
			end

			if (state_q == ST_EMIT && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_tick) begin
			k_q      <= sidx_q;
			c_q      <= cnt_q[TICK_W-1:0];
			inramp_q <= cnt_q < {1'b0, ramp_q};
			mag_q    <= '0;
			cyc_q    <= down_phase_q && down_end && rev_q;
			fin_q    <= down_phase_q && down_end && rev_q && !rep_q;
		end
		if (div_done) begin
			unique case (state_q)
				ST_LO:   lo_q  <= div_q;
				ST_HI:   mag_q <= div_q;
				ST_FRAC: mag_q <= lo_q + div_q;
				ST_DOWN: mag_q <= div_q;
				default: begin
				end
			endcase
		end
		if (state_q == ST_EMIT && out_free) begin
			ref_q     <= rev_q ? REF_W'(0) - {1'b0, sat} : {1'b0, sat};
			cyc_out_q <= cyc_q;
			fin_out_q <= fin_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign reference      = $signed(ref_q);
	assign cycle_complete = cyc_out_q;
	assign finished       = fin_out_q;

endmodule

`default_nettype wire

// ===== design/srp_checker.sv =====
// Port-level checks for the staircase ramp profile generator, bound to the top.
// Depends on srp_pkg and staircase_ramp_profile.
`default_nettype none

module srp_checker
	import srp_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 out_valid,
	input wire logic                 out_stall,
	input wire logic signed [REF_W-1:0] reference,
	input wire logic                 cycle_complete,
	input wire logic                 finished
);

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(reference) && $stable(finished))
		else $error("stalled result changed");

	a_fin_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && finished |-> cycle_complete)
		else $error("finished without cycle_complete");

	a_cycle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cycle_complete |-> reference == '0)
		else $error("cycle end with nonzero reference");

	a_ref_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> reference != {1'b1, {(REF_W-1){1'b0}}})
		else $error("reference out of symmetric range");

endmodule

bind staircase_ramp_profile srp_checker u_srp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.reference      (reference),
	.cycle_complete (cycle_complete),
	.finished       (finished)
);

`default_nettype wire

// ===== sim/staircase_ramp_profile_test.sv =====
// Self-checking testbench for staircase_ramp_profile: directed and random ticks
// against a built-in predictor of the staircase, ramp-down and polarity sequence.
// Depends on srp_pkg and the staircase_ramp_profile top level.
`default_nettype none

module staircase_ramp_profile_test;
	import srp_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
	localparam int IDLE_PCT  = 38;
	localparam int LONG_HOLD = 300;
	localparam int TARGET_TICKS = 1950;

	typedef struct packed {
		logic [REF_W-1:0] level;
		logic             cyc_done;
		logic             fin;
	} profile_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic restart = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [REF_W-1:0] reference;
	logic cycle_complete;
	logic finished;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	staircase_ramp_profile dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.restart(restart),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.reference(reference),
		.cycle_complete(cycle_complete),
		.finished(finished),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial forever #1 clk = ~clk;

	// predictor copy of the registers
	logic [MAX_W-1:0]  pk_max    = RST_MAX_REFERENCE;
	logic [STEP_W-1:0] pk_steps  = RST_STEP_COUNT;
	logic [TICK_W-1:0] pk_ramp   = RST_RAMP_TICKS;
	logic [TICK_W-1:0] pk_hold   = RST_HOLD_TICKS;
	logic [TICK_W-1:0] pk_down   = RST_DOWN_TICKS;
	logic              pk_repeat = 1'b0;
	// predictor copy of the sequence state
	logic [CNT_W-1:0]  tick_cnt  = '0;
	logic [STEP_W-1:0] step_idx  = '0;
	logic              in_down   = 1'b0;
	logic              reversed  = 1'b0;
	logic              pred_halted = 1'b1;

	logic tick_q[$];
	profile_t expected_refs[$];
	logic in_taken = 1'b0;

	int ticks_sent = 0;
	int ticks_taken = 0;
	int live_ticks = 0;
	int results_seen = 0;
	int cycle_ends = 0;
	int finishes = 0;
	int settings_used = 0;
	int mismatches = 0;
	int cycle_count = 0;
	int hold_left = 0;
	int next_hold_at = 200;

	logic calm;
	assign calm = (cycle_count >= 20000) && (cycle_count < 35000);

	function automatic longint unsigned level_at(longint unsigned k, longint unsigned div);
		longint unsigned m;
		m = 64'(pk_max);
		if (k > div)
			k = div;
		return (m * k) / div;
	endfunction

	// Advance the profile by one tick; returns 1 when the tick yields a result.
	function automatic bit advance_profile(input logic rs, output profile_t res);
		longint unsigned mag, div, lo, hi, m, r, h, d, c;
		logic [REF_W-1:0] m16;
		res = '0;
		if (rs) begin
			tick_cnt = '0;
			step_idx = '0;
			in_down = 1'b0;
			reversed = 1'b0;
			pred_halted = 1'b0;
			return 1'b0;
		end
		if (pred_halted)
			return 1'b0;
		m = 64'(pk_max);
		r = 64'(pk_ramp);
		h = 64'(pk_hold);
		d = 64'(pk_down);
		c = 64'(tick_cnt);
		mag = 0;
		if (in_down) begin
			if (c >= d) begin
				mag = 0;
				in_down = 1'b0;
				step_idx = '0;
				tick_cnt = '0;
				if (!reversed) begin
					reversed = 1'b1;
				end else begin
					reversed = 1'b0;
					res.cyc_done = 1'b1;
					if (!pk_repeat) begin
						res.fin = 1'b1;
						pred_halted = 1'b1;
					end
				end
			end else begin
				mag = (m * (d - c)) / d;
			end
			tick_cnt = tick_cnt + CNT_W'(1);
		end else begin
			div = (pk_steps != '0) ? 64'(pk_steps) : 64'd1;
			lo = level_at(64'(step_idx), div);
			hi = level_at(64'(step_idx) + 64'd1, div);
			if (c < r)
				mag = lo + ((hi - lo) * c) / r;
			else
				mag = hi;
			tick_cnt = tick_cnt + CNT_W'(1);
			c = 64'(tick_cnt);
			if (c >= r + h) begin
				tick_cnt = '0;
				step_idx = step_idx + STEP_W'(1);
				if (64'(step_idx) >= div)
					in_down = 1'b1;
			end
		end
		if (mag > 32767)
			mag = 32767;
		m16 = mag[REF_W-1:0];
		res.level = reversed ? (16'd0 - m16) : m16;
		return 1'b1;
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_MAX_REFERENCE: pk_max = data[MAX_W-1:0];
			CFG_STEP_COUNT:    pk_steps = data[STEP_W-1:0];
			CFG_RAMP_TICKS:    pk_ramp = data[TICK_W-1:0];
			CFG_HOLD_TICKS:    pk_hold = data[TICK_W-1:0];
			CFG_DOWN_TICKS:    pk_down = data[TICK_W-1:0];
			CFG_REPEAT_ENABLE: pk_repeat = data[0];
			default: ;
		endcase
	endfunction

	// Fill the bits above the register width with noise; the block must drop them.
	function automatic logic [CFG_DATA_W-1:0] dirty(int unsigned v, int w);
		logic [31:0] junk;
		junk = $urandom;
		return CFG_DATA_W'(v) | CFG_DATA_W'(junk << w);
	endfunction

	function automatic int unsigned pick_range(int unsigned lo, int unsigned hi);
		case ($urandom_range(0, 3))
			0: return lo;
			1: return hi;
			default: return $urandom_range(hi, lo);
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		apply_reg(idx, data);
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_data <= CFG_DATA_W'($urandom);
		settings_used++;
	endtask

	task automatic send_tick(input logic r);
		@(posedge clk);
		while (tick_q.size() >= 2)
			@(posedge clk);
		tick_q.push_back(r);
		ticks_sent++;
	endtask

	task automatic send_run(input logic r, input int count);
		repeat (count)
			send_tick(r);
	endtask

	// Wait until every tick is taken and every result is in, then let the block settle.
	task automatic drain();
		do
			@(negedge clk);
		while (ticks_taken != ticks_sent || expected_refs.size() != 0);
		repeat (80) @(negedge clk);
	endtask

	// Sender: present the next pending tick, hold while stalled.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			restart <= 1'b0;
		end else if (in_valid && !in_taken) begin
			// hold the stalled transfer
		end else if (tick_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
			in_valid <= 1'b1;
			restart <= tick_q.pop_front();
		end else begin
			in_valid <= 1'b0;
			restart <= 1'($urandom_range(0, 1));
		end
	end

	// Receiver: random stalls, plus a long hold-off every so often.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (results_seen >= next_hold_at) begin
			out_stall <= 1'b1;
			hold_left <= LONG_HOLD;
			next_hold_at <= next_hold_at + 900;
		end else if (calm) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// Check each result transfer, then predict from each tick transfer.
	always @(posedge clk) begin : watch
		profile_t want;
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			cycle_count++;
			if (out_valid && !out_stall) begin
				results_seen++;
				if (cycle_complete)
					cycle_ends++;
				if (finished)
					finishes++;
				if (expected_refs.size() == 0) begin
					mismatches++;
					$display("%0t: result expected none actual reference %0d cycle_complete %b finished %b",
						$time, reference, cycle_complete, finished);
				end else begin
					want = expected_refs.pop_front();
					if (reference !== want.level) begin
						mismatches++;
						$display("%0t: reference expected %0d actual %0d", $time,
							$signed(want.level), reference);
					end
					if (cycle_complete !== want.cyc_done) begin
						mismatches++;
						$display("%0t: cycle_complete expected %b actual %b", $time,
							want.cyc_done, cycle_complete);
					end
					if (finished !== want.fin) begin
						mismatches++;
						$display("%0t: finished expected %b actual %b", $time,
							want.fin, finished);
					end
				end
			end
			if (in_valid && !in_stall) begin
				ticks_taken++;
				if (restart || !pred_halted)
					live_ticks++;
				if (advance_profile(restart, want))
					expected_refs.push_back(want);
			end
			in_taken <= in_valid && !in_stall;
		end
	end

	initial begin
		#4000000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		logic r;
		logic wide;
		int n;
		int k;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// registers at reset: a tick while stopped, then a restart and the first ramp ticks
		send_tick(1'b0);
		send_tick(1'b1);
		send_run(1'b0, 3);
		drain();

		// shortest full cycle at full scale, no repeat: ends stopped
		write_reg(CFG_MAX_REFERENCE, 16'd32767);
		write_reg(CFG_STEP_COUNT, 16'd1);
		write_reg(CFG_RAMP_TICKS, 16'd1);
		write_reg(CFG_HOLD_TICKS, 16'd0);
		write_reg(CFG_DOWN_TICKS, 16'd1);
		write_reg(CFG_REPEAT_ENABLE, 16'd0);
		end_writes();
		send_tick(1'b1);
		send_run(1'b0, 7);
		drain();

		// zero step count, zero ramp, zero ramp-down, repeat on, noise above the fields
		write_reg(CFG_MAX_REFERENCE, 16'hB039);
		write_reg(CFG_STEP_COUNT, 16'hFF00);
		write_reg(CFG_RAMP_TICKS, 16'd0);
		write_reg(CFG_DOWN_TICKS, 16'd0);
		write_reg(CFG_REPEAT_ENABLE, 16'hFFFF);
		write_reg(CFG_SPARE_LO, 16'hFFFF);
		write_reg(CFG_SPARE_HI, 16'h5A5A);
		end_writes();
		send_tick(1'b1);
		send_run(1'b0, 6);
		send_tick(1'b1);
		send_run(1'b0, 1);
		drain();

		// widest counts, changed in the middle of a ramp-down
		write_reg(CFG_MAX_REFERENCE, 16'd1);
		write_reg(CFG_STEP_COUNT, 16'd255);
		write_reg(CFG_RAMP_TICKS, 16'hFFFF);
		write_reg(CFG_HOLD_TICKS, 16'hFFFF);
		write_reg(CFG_DOWN_TICKS, 16'hFFFF);
		end_writes();
		send_run(1'b0, 3);
		drain();

		while (live_ticks < TARGET_TICKS) begin
			wide = ($urandom_range(0, 4) == 0);
			if (wide) begin
				write_reg(CFG_MAX_REFERENCE, dirty(pick_range(0, 32767), MAX_W));
				write_reg(CFG_STEP_COUNT, dirty(pick_range(1, 255), STEP_W));
				write_reg(CFG_RAMP_TICKS, dirty(pick_range(1, 65535), TICK_W));
				write_reg(CFG_HOLD_TICKS, dirty(pick_range(0, 65535), TICK_W));
				write_reg(CFG_DOWN_TICKS, dirty(pick_range(1, 65535), TICK_W));
				n = $urandom_range(10, 30);
			end else begin
				write_reg(CFG_MAX_REFERENCE, dirty(pick_range(0, 32767), MAX_W));
				write_reg(CFG_STEP_COUNT, dirty($urandom_range(1, 6), STEP_W));
				write_reg(CFG_RAMP_TICKS, dirty($urandom_range(1, 8), TICK_W));
				write_reg(CFG_HOLD_TICKS, dirty($urandom_range(0, 6), TICK_W));
				write_reg(CFG_DOWN_TICKS, dirty($urandom_range(1, 12), TICK_W));
				n = $urandom_range(40, 160);
			end
			write_reg(CFG_REPEAT_ENABLE, dirty($urandom_range(0, 1), 1));
			if ($urandom_range(0, 5) == 0)
				write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
					CFG_DATA_W'($urandom));
			end_writes();
			// half the phases carry on from where the last setting left the sequence
			if ($urandom_range(0, 1))
				send_tick(1'b1);
			for (k = 0; k < n; k++) begin
				@(negedge clk);
				r = pred_halted ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 99) < 2);
				send_tick(r);
			end
			drain();
		end

		for (k = 0; k < 20000 && (ticks_taken != ticks_sent || expected_refs.size() != 0); k++)
			@(negedge clk);
		repeat (100) @(negedge clk);
		if (expected_refs.size() != 0) begin
			mismatches += expected_refs.size();
			$display("%0t: %0d results expected but never seen", $time, expected_refs.size());
		end
		$display("Ran %0d ticks (%0d active) over %0d register settings", ticks_taken,
			live_ticks, settings_used);
		$display("Checked %0d results, %0d full cycles, %0d stops", results_seen, cycle_ends,
			finishes);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
design/srp_pkg.sv
design/srp_muldiv.sv
design/staircase_ramp_profile.sv
design/srp_checker.sv
sim/staircase_ramp_profile_test.sv
